/* hdl/record_table_sort_search_top_macros.svh */
// assertion macros shared by the table block
`ifndef RECORD_TABLE_SORT_SEARCH_TOP_MACROS_SVH
`define RECORD_TABLE_SORT_SEARCH_TOP_MACROS_SVH

// implication checked at every clock edge outside reset
`define RTS_ASSERT_IMPL(label, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// implication whose right side is checked in the cycle after the left side holds
`define RTS_ASSERT_NEXT(label, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

/* hdl/rts_pkg.sv */
package rts_pkg;

    localparam int CAPACITY_DEF  = 16;
    localparam int KEY_CHARS_DEF = 8;
    localparam int KEY_W         = 64;
    localparam int VAL_W         = 32;
    localparam int CMP_W         = 7;

    localparam logic [2:0] KIND_ADD    = 3'd0;
    localparam logic [2:0] KIND_REMOVE = 3'd1;
    localparam logic [2:0] KIND_SNAME  = 3'd2;
    localparam logic [2:0] KIND_STYPE  = 3'd3;
    localparam logic [2:0] KIND_SRANK  = 3'd4;
    localparam logic [2:0] KIND_SEARCH = 3'd5;
    localparam logic [2:0] KIND_READ   = 3'd6;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    // datapath operation selects
    typedef enum logic [2:0] {
        DP_NONE,
        DP_LOAD_A,
        DP_LOAD_B,
        DP_WRITE_IN,
        DP_WRITE_A,
        DP_WRITE_B,
        DP_REPORT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [5:0] addr;
        logic       clear_out;
    } dp_cmd_t;

    typedef struct packed {
        logic name_gt;    // a.name > b.name
        logic type_gt;    // b.type > a.type
        logic rank_lt;    // b.rank < a.rank
        logic name_eq_in;
        logic name_lt_in; // b.name < input name
        logic match_in;   // b matches input name and type
    } dp_stat_t;

endpackage

/* hdl/rts_ram.sv */
module rts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* hdl/rts_datapath.sv */
module rts_datapath #(
    parameter int CAPACITY  = rts_pkg::CAPACITY_DEF,
    parameter int KEY_CHARS = rts_pkg::KEY_CHARS_DEF
) (
    input  logic                              clk,
    input  logic                              load_in,
    input  logic [rts_pkg::KEY_W-1:0]         name_key,
    input  logic [rts_pkg::KEY_W-1:0]         type_key,
    input  logic signed [rts_pkg::VAL_W-1:0]  amount,
    input  logic signed [rts_pkg::VAL_W-1:0]  rank,
    input  rts_pkg::dp_cmd_t                  cmd,
    output rts_pkg::dp_stat_t                 stat,
    output logic [rts_pkg::KEY_W-1:0]         out_name,
    output logic [rts_pkg::KEY_W-1:0]         out_type,
    output logic signed [rts_pkg::VAL_W-1:0]  out_amount,
    output logic signed [rts_pkg::VAL_W-1:0]  out_rank
);
    import rts_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int RW = 2 * KEY_W + 2 * VAL_W;
    localparam logic [KEY_W-1:0] KEY_MASK = ~64'd0 << (KEY_W - 8 * KEY_CHARS);

    logic [KEY_W-1:0] in_name_reg, in_type_reg;
    logic [VAL_W-1:0] in_amt_reg, in_rank_reg;
    logic [RW-1:0]    a_reg, b_reg, rdata, wdata;
    logic             we, pend_a_reg, pend_b_reg, pend_r_reg;
    logic [KEY_W-1:0] an, at, bn, bt;
    logic [VAL_W-1:0] ar, br;

    assign we = (cmd.op == DP_WRITE_IN) || (cmd.op == DP_WRITE_A) || (cmd.op == DP_WRITE_B);

    always_comb
    begin
        unique case (cmd.op)
            DP_WRITE_A: wdata = a_reg;
            DP_WRITE_B: wdata = b_reg;
            default:    wdata = {in_name_reg, in_type_reg, in_amt_reg, in_rank_reg};
        endcase
    end

    rts_ram #(.WIDTH(RW), .DEPTH(CAPACITY)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (cmd.addr[AW-1:0]),
        .wdata (wdata),
        .raddr (cmd.addr[AW-1:0]),
        .rdata (rdata)
    );

    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            in_name_reg <= name_key & KEY_MASK;
            in_type_reg <= type_key & KEY_MASK;
            in_amt_reg  <= amount;
            in_rank_reg <= rank;
        end
        pend_a_reg <= (cmd.op == DP_LOAD_A);
        pend_b_reg <= (cmd.op == DP_LOAD_B);
        pend_r_reg <= (cmd.op == DP_REPORT);
        if (pend_a_reg)
        begin
            a_reg <= rdata;
        end
        if (pend_b_reg)
        begin
            b_reg <= rdata;
        end
        if (cmd.clear_out)
        begin
            {out_name, out_type, out_amount, out_rank} <= '0;
        end
        else if (pend_r_reg)
        begin
            {out_name, out_type, out_amount, out_rank} <= rdata;
        end
    end

    assign {an, at, ar} = {a_reg[RW-1 -: 2*KEY_W], a_reg[VAL_W-1:0]};
    assign {bn, bt, br} = {b_reg[RW-1 -: 2*KEY_W], b_reg[VAL_W-1:0]};

    always_comb
    begin
        stat.name_gt    = an > bn;
        stat.type_gt    = bt > at;
        stat.rank_lt    = $signed(br) < $signed(ar);
        stat.name_eq_in = bn == in_name_reg;
        stat.name_lt_in = bn < in_name_reg;
        stat.match_in   = (bn == in_name_reg) && (bt == in_type_reg);
    end
endmodule

/* hdl/rts_ctrl.sv */
module rts_ctrl #(
    parameter int CAPACITY = rts_pkg::CAPACITY_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [2:0]                 kind,
    input  logic [3:0]                 slot,
    output logic                       load_in,
    output rts_pkg::dp_cmd_t           cmd,
    input  rts_pkg::dp_stat_t          stat,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [1:0]                 status,
    output logic [4:0]                 fill,
    output logic [3:0]                 where_found,
    output logic [rts_pkg::CMP_W-1:0]  compare_count
);
    import rts_pkg::*;
    `include "record_table_sort_search_top_macros.svh"

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = 7;
    // internal kind for the selection swap tail; users must not issue it, the block does not enforce this
    localparam logic [2:0] KIND_SWAP = 3'd7;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_DISP  = 12'b000000000010,
        S_RDA   = 12'b000000000100,
        S_WA    = 12'b000000001000,
        S_RDB   = 12'b000000010000,
        S_WB    = 12'b000000100000,
        S_EVAL  = 12'b000001000000,
        S_WR1   = 12'b000010000000,
        S_WR2   = 12'b000100000000,
        S_RPT   = 12'b001000000000,
        S_RPTW  = 12'b010000000000,
        S_DONE  = 12'b100000000000
    } state_t;

    state_t           state_reg, state_next;
    logic [2:0]       kind_reg, kind_next;
    logic [3:0]       slot_reg, slot_next;
    logic [CW-1:0]    count_reg, count_next;
    logic signed [IW-1:0] i_reg, i_next, j_reg, j_next, m_reg, m_next;
    logic signed [IW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic             flag_reg, flag_next;
    logic [1:0]       status_reg, status_next;
    logic [3:0]       where_reg, where_next;
    logic [7:0]       cmp_reg, cmp_next;
    logic [IW-1:0]    addr_a, addr_b;
    logic signed [IW-1:0] mid;
    logic signed [IW-1:0] n_s;

    assign n_s = IW'(count_reg);
    assign mid = lo_reg + ((hi_reg - lo_reg) >>> 1);

    // which address pair each algorithm loads
    always_comb
    begin
        addr_a = '0;
        addr_b = '0;
        case (kind_reg)
            KIND_SNAME: begin addr_a = j_reg; addr_b = j_reg + 1'b1; end
            KIND_STYPE: begin addr_a = j_reg; addr_b = j_reg - 1'b1; end
            KIND_SRANK: begin addr_a = m_reg; addr_b = j_reg; end
            KIND_SEARCH: begin addr_a = mid; addr_b = mid; end
            default:    begin addr_a = j_reg; addr_b = j_reg; end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        slot_next   = slot_reg;
        count_next  = count_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        m_next      = m_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        flag_next   = flag_reg;
        status_next = status_reg;
        where_next  = where_reg;
        cmp_next    = cmp_reg;
        cmd         = '{op: DP_NONE, addr: '0, clear_out: 1'b0};
        load_in     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    load_in     = 1'b1;
                    cmd.clear_out = 1'b1;
                    kind_next   = kind;
                    slot_next   = slot;
                    status_next = ST_OK;
                    where_next  = '0;
                    cmp_next    = '0;
                    i_next      = '0;
                    j_next      = '0;
                    flag_next   = 1'b0;
                    state_next  = S_DISP;
                end
            end
            S_DISP:
            begin
                state_next = S_DONE;
                case (kind_reg)
                    KIND_ADD:
                    begin
                        if (count_reg >= CW'(CAPACITY))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            cmd.op     = DP_WRITE_IN;
                            cmd.addr   = 6'(count_reg);
                            count_next = count_reg + 1'b1;
                        end
                    end
                    KIND_REMOVE:
                    begin
                        // j scans for match, flag set once found and shifting
                        if (count_reg == '0)
                        begin
                            status_next = ST_NOTFOUND;
                        end
                        else
                        begin
                            state_next = S_RDB;
                        end
                    end
                    KIND_SNAME:
                    begin
                        if (n_s > 1)
                        begin
                            state_next = S_RDA;
                        end
                    end
                    KIND_STYPE:
                    begin
                        if (n_s > 1)
                        begin
                            i_next     = 7'sd1;
                            j_next     = 7'sd1;
                            state_next = S_RDA;
                        end
                    end
                    KIND_SRANK:
                    begin
                        if (n_s > 1)
                        begin
                            m_next     = '0;
                            j_next     = 7'sd1;
                            state_next = S_RDA;
                        end
                    end
                    KIND_SEARCH:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            lo_next     = '0;
                            hi_next     = n_s - 1'b1;
                            status_next = ST_NOTFOUND;
                            state_next  = S_RDB;
                        end
                    end
                    KIND_READ:
                    begin
                        if (CW'(slot_reg) >= count_reg)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            where_next = slot_reg;
                            cmd.op     = DP_REPORT;
                            cmd.addr   = 6'(slot_reg);
                            state_next = S_RPTW;
                        end
                    end
                    default: ;
                endcase
            end
            S_RDA:
            begin
                cmd.op     = DP_LOAD_A;
                cmd.addr   = 6'(addr_a);
                state_next = S_WA;
            end
            S_WA:
            begin
                state_next = S_RDB;
            end
            S_RDB:
            begin
                cmd.op     = DP_LOAD_B;
                cmd.addr   = 6'(addr_b);
                state_next = S_WB;
            end
            S_WB:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = S_RDA;
                case (kind_reg)
                    KIND_REMOVE:
                    begin
                        if (flag_reg)
                        begin
                            // b holds entry j, store it one lower
                            cmd.op   = DP_WRITE_B;
                            cmd.addr = 6'(j_reg - 1'b1);
                            j_next   = j_reg + 1'b1;
                            if (j_reg + 1'b1 >= n_s)
                            begin
                                count_next = count_reg - 1'b1;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_RDB;
                            end
                        end
                        else if (stat.match_in)
                        begin
                            flag_next = 1'b1;
                            j_next    = j_reg + 1'b1;
                            if (j_reg + 1'b1 >= n_s)
                            begin
                                count_next = count_reg - 1'b1;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_RDB;
                            end
                        end
                        else
                        begin
                            j_next = j_reg + 1'b1;
                            if (j_reg + 1'b1 >= n_s)
                            begin
                                status_next = ST_NOTFOUND;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_RDB;
                            end
                        end
                    end
                    KIND_SNAME:
                    begin
                        cmp_next = cmp_reg + 1'b1;
                        if (stat.name_gt)
                        begin
                            flag_next = 1'b1;
                            state_next = S_WR1;
                        end
                        else
                        begin
                            state_next = S_WR2;
                        end
                    end
                    KIND_STYPE:
                    begin
                        // a is the key record at j, b is entry j-1
                        cmp_next = cmp_reg + 1'b1;
                        if (stat.type_gt)
                        begin
                            state_next = S_WR1;
                        end
                        else
                        begin
                            state_next = S_WR2;
                        end
                    end
                    KIND_SRANK:
                    begin
                        cmp_next = cmp_reg + 1'b1;
                        if (stat.rank_lt)
                        begin
                            m_next = j_reg;
                        end
                        if (j_reg + 1'b1 < n_s)
                        begin
                            j_next     = j_reg + 1'b1;
                            state_next = stat.rank_lt ? S_RDA : S_RDB;
                        end
                        else
                        begin
                            state_next = S_WR1;
                        end
                    end
                    KIND_SEARCH:
                    begin
                        cmp_next = cmp_reg + 1'b1;
                        if (stat.name_eq_in)
                        begin
                            status_next = ST_OK;
                            where_next  = 4'(mid);
                            state_next  = S_RPT;
                        end
                        else
                        begin
                            if (stat.name_lt_in)
                            begin
                                lo_next = mid + 1'b1;
                            end
                            else
                            begin
                                hi_next = mid - 1'b1;
                            end
                            // stop once the window is empty
                            if ((stat.name_lt_in && (mid >= hi_reg))
                                || (!stat.name_lt_in && (lo_reg >= mid)))
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_RDB;
                            end
                        end
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_WR1:
            begin
                case (kind_reg)
                    KIND_SNAME:
                    begin
                        cmd.op     = DP_WRITE_B;
                        cmd.addr   = 6'(j_reg);
                        state_next = S_WR2;
                    end
                    KIND_STYPE:
                    begin
                        // shift entry j-1 up, keep key in a
                        cmd.op   = DP_WRITE_B;
                        cmd.addr = 6'(j_reg);
                        j_next   = j_reg - 1'b1;
                        if (j_reg - 1'b1 == '0)
                        begin
                            state_next = S_WR2;
                        end
                        else
                        begin
                            state_next = S_RDB;
                        end
                    end
                    default:
                    begin
                        // selection: swap i and m; load entry m into a first
                        if (m_reg != i_reg)
                        begin
                            cmd.op     = DP_LOAD_A;
                            cmd.addr   = 6'(m_reg);
                            flag_next  = 1'b1;
                            state_next = S_WR2;
                        end
                        else
                        begin
                            flag_next  = 1'b0;
                            state_next = S_WR2;
                        end
                    end
                endcase
            end
            S_WR2:
            begin
                case (kind_reg)
                    KIND_SNAME:
                    begin
                        if (cmd.op == DP_NONE && flag_reg && stat.name_gt)
                        begin
                            cmd.op   = DP_WRITE_A;
                            cmd.addr = 6'(j_reg + 1'b1);
                        end
                        if (j_reg + 2 < n_s - i_reg)
                        begin
                            j_next     = j_reg + 1'b1;
                            state_next = S_RDA;
                        end
                        else if (flag_reg && (i_reg + 2 < n_s))
                        begin
                            i_next     = i_reg + 1'b1;
                            j_next     = '0;
                            flag_next  = 1'b0;
                            state_next = S_RDA;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    KIND_STYPE:
                    begin
                        cmd.op   = DP_WRITE_A;
                        cmd.addr = 6'(j_reg);
                        if (i_reg + 1'b1 < n_s)
                        begin
                            i_next     = i_reg + 1'b1;
                            j_next     = i_reg + 1'b1;
                            state_next = S_RDA;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    default:
                    begin
                        // load entry i into b while entry m settles in a
                        if (flag_reg)
                        begin
                            cmd.op   = DP_LOAD_B;
                            cmd.addr = 6'(i_reg);
                        end
                        state_next = S_WR2;
                        kind_next  = KIND_SWAP;
                    end
                endcase
                if (kind_reg == KIND_SWAP)
                begin
                    // selection swap tail: a holds entry m, b holds entry i
                    if (flag_reg)
                    begin
                        cmd.op   = DP_WRITE_A;
                        cmd.addr = 6'(i_reg);
                        flag_next = 1'b0;
                        state_next = S_WR2;
                        kind_next  = KIND_SWAP;
                        j_next = m_reg;
                    end
                    else
                    begin
                        if (j_reg != i_reg || m_reg != i_reg)
                        begin
                            if (m_reg != i_reg)
                            begin
                                cmd.op   = DP_WRITE_B;
                                cmd.addr = 6'(m_reg);
                            end
                        end
                        kind_next = KIND_SRANK;
                        if (i_reg + 2 < n_s)
                        begin
                            i_next     = i_reg + 1'b1;
                            m_next     = i_reg + 1'b1;
                            j_next     = i_reg + 7'sd2;
                            state_next = S_RDA;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                end
            end
            S_RPT:
            begin
                cmd.op     = DP_REPORT;
                cmd.addr   = 6'(mid);
                state_next = S_RPTW;
            end
            S_RPTW:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            kind_reg   <= '0;
            flag_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            kind_reg   <= kind_next;
            flag_reg   <= flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg   <= slot_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        m_reg      <= m_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        status_reg <= status_next;
        where_reg  <= where_next;
        cmp_reg    <= cmp_next;
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = (state_reg == S_DONE);
    assign status        = status_reg;
    assign fill          = 5'(count_reg);
    assign where_found   = where_reg;
    assign compare_count = (cmp_reg > 8'd127) ? 7'd127 : cmp_reg[6:0];

    `RTS_ASSERT_IMPL(a_fill_range, 1'b1, count_reg <= CW'(CAPACITY), "fill beyond capacity")
    `RTS_ASSERT_IMPL(a_busy_no_out, in_stall && !out_valid, !out_valid, "unexpected output")
    `RTS_ASSERT_NEXT(a_accept_disp, state_reg == S_IDLE && in_valid, state_reg == S_DISP,
        "accepted item not dispatched")
    `RTS_ASSERT_NEXT(a_hold_done, out_valid && out_stall, out_valid && $stable(status),
        "stalled result changed")
endmodule

/* hdl/record_table_sort_search_top.sv */
// record table with sorting and binary search
// input channel: in_valid / in_stall carry one command transaction (kind and
// its operands); the block stalls its input while a command is in work
// output channel: out_valid / out_stall carry one result transaction per
// command, held stable while out_stall is high
// add, read and unused kinds need no table walk; remove walks the table
// once, reading one entry per step; the sorts run one compare per loop
// step through a single ram read port
// throughput: one command at a time; the next is taken the cycle after the
// result transaction completes
// reset clears the entry count and the controller; entry storage has no
// reset and is only read below the fill count
module record_table_sort_search_top #(
    parameter int CAPACITY  = rts_pkg::CAPACITY_DEF,
    parameter int KEY_CHARS = rts_pkg::KEY_CHARS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [2:0]                        kind,
    input  logic [rts_pkg::KEY_W-1:0]         name_key,
    input  logic [rts_pkg::KEY_W-1:0]         type_key,
    input  logic signed [rts_pkg::VAL_W-1:0]  amount,
    input  logic signed [rts_pkg::VAL_W-1:0]  rank,
    input  logic [3:0]                        slot,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        status,
    output logic [4:0]                        fill,
    output logic [3:0]                        where_found,
    output logic [rts_pkg::KEY_W-1:0]         out_name,
    output logic [rts_pkg::KEY_W-1:0]         out_type,
    output logic signed [rts_pkg::VAL_W-1:0]  out_amount,
    output logic signed [rts_pkg::VAL_W-1:0]  out_rank,
    output logic [rts_pkg::CMP_W-1:0]         compare_count
);
    import rts_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     load_in;

    rts_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .slot          (slot),
        .load_in       (load_in),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .fill          (fill),
        .where_found   (where_found),
        .compare_count (compare_count)
    );

    rts_datapath #(.CAPACITY(CAPACITY), .KEY_CHARS(KEY_CHARS)) u_dp (
        .clk        (clk),
        .load_in    (load_in),
        .name_key   (name_key),
        .type_key   (type_key),
        .amount     (amount),
        .rank       (rank),
        .cmd        (cmd),
        .stat       (stat),
        .out_name   (out_name),
        .out_type   (out_type),
        .out_amount (out_amount),
        .out_rank   (out_rank)
    );
endmodule
